@@ rtl/b64se_pkg.sv @@
// Shared types, codes and the character table of the Base64 stream encoder.
package b64se_pkg;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD  = 2'd2;

	localparam logic [7:0] CHAR_PAD = 8'h3d;  // '='

	// Up to three characters made by one input item, in emit order.
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] ch;
	} char_group_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + ({2'b00, v} - 8'd26);
		end else if (v < 6'd62) begin
			r = 8'h30 + ({2'b00, v} - 8'd52);
		end else if (v == 6'd62) begin
			r = 8'h2b;  // '+'
		end else begin
			r = 8'h2f;  // '/'
		end
		return r;
	endfunction

endpackage

@@ rtl/b64se_front.sv @@
// Front end: accepts items, tracks the group phase and builds character groups.
module b64se_front
	import b64se_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  logic        q_full,
	output logic        q_push,
	output char_group_t q_entry
);

	logic [1:0] phase_q;
	logic [5:0] carry_q;
	logic [1:0] phase_nxt;
	logic [5:0] carry_nxt;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		q_entry   = '0;
		phase_nxt = PHASE_FIRST;
		carry_nxt = '0;
		if (opcode_t'(opcode) == OP_DATA) begin
			case (phase_q)
				PHASE_SECOND: begin
					q_entry.cnt   = 2'd1;
					q_entry.ch[0] = b64_char(carry_q | {2'b00, data_byte[7:4]});
					carry_nxt     = {data_byte[3:0], 2'b00};
					phase_nxt     = PHASE_THIRD;
				end
				PHASE_THIRD: begin
					q_entry.cnt   = 2'd2;
					q_entry.ch[0] = b64_char(carry_q | {4'b0000, data_byte[7:6]});
					q_entry.ch[1] = b64_char(data_byte[5:0]);
				end
				default: begin
					q_entry.cnt   = 2'd1;
					q_entry.ch[0] = b64_char(data_byte[7:2]);
					carry_nxt     = {data_byte[1:0], 4'b0000};
					phase_nxt     = PHASE_SECOND;
				end
			endcase
		end else begin
			case (phase_q)
				PHASE_SECOND: begin
					q_entry.cnt   = 2'd3;
					q_entry.ch[0] = b64_char(carry_q);
					q_entry.ch[1] = CHAR_PAD;
					q_entry.ch[2] = CHAR_PAD;
				end
				PHASE_THIRD: begin
					q_entry.cnt   = 2'd2;
					q_entry.ch[0] = b64_char(carry_q);
					q_entry.ch[1] = CHAR_PAD;
				end
				default: begin
					q_entry.cnt = 2'd0;
				end
			endcase
		end
	end

	// A flush at a group boundary makes no characters: drop it here.
	assign q_push = accept && (q_entry.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_FIRST;
			carry_q <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			carry_q <= carry_nxt;
		end
	end

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("group phase reached unused code");
	a_carry_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PHASE_FIRST |-> carry_q == 6'd0)
		else $error("carried bits left at group start");

endmodule

@@ rtl/b64se_queue.sv @@
// Short register queue of character groups between front and back.
module b64se_queue
	import b64se_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  char_group_t push_data,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output char_group_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	char_group_t        slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count over depth");

endmodule

@@ rtl/b64se_back.sv @@
// Back end: unpacks character groups into one output character per transfer.
module b64se_back
	import b64se_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  char_group_t q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        run_last
);

	char_group_t cur_q;
	logic        cur_valid_q;
	logic [1:0]  idx_q;
	logic        valid_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic        load;
	logic        is_last;

	assign is_last = (idx_q == cur_q.cnt - 2'd1);
	assign load    = cur_valid_q && (!valid_q || !out_stall);
	assign q_pop   = q_not_empty && (!cur_valid_q || (load && is_last));

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign run_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= cur_q.ch[idx_q];
			last_q <= is_last;
		end
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (load) begin
				if (is_last) begin
					cur_valid_q <= 1'b0;
					idx_q       <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_q.cnt != 2'd0) && (idx_q < cur_q.cnt))
		else $error("character index outside group");

endmodule

@@ rtl/base64_stream_encoder.sv @@
// Top level of the streaming Base64 encoder.
//
// Streaming Base64 encoder, standard alphabet with '+' and '/' and '=' pad.
// Each input transfer carries one raw byte (opcode data) or a flush request
// (opcode flush); each output transfer carries one ASCII character, and
// run_last marks the last character made by an input item. A data byte makes
// one character at the first and second byte of a group and two at the
// third; a flush makes the pending character plus "==" or "=", or nothing at
// a group boundary, and starts a new group. The front end classifies an item
// in the cycle it is accepted and pushes its characters as one group into a
// short queue (QUEUE_DEPTH groups); the back end drains that queue through a
// registered output at one character per cycle while the output is not
// stalled. The output port sets the rate: an item takes output bandwidth
// for each character it makes, so a steady byte stream costs four output
// characters per three bytes. With the queue empty and the back end idle, a
// first character passes from a queue slot through the group register of
// the back end into its output register. Input is taken whenever the queue
// has room, also while a character waits on a stalled output.
module base64_stream_encoder
	import b64se_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_last
);

	// Front to queue.
	logic        q_full;
	logic        q_push;
	char_group_t q_entry;

	// Queue to back.
	logic        q_not_empty;
	logic        q_pop;
	char_group_t q_head;

	b64se_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	b64se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	b64se_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_last    (run_last)
	);

	// Hold back input exactly when the queue is out of room.
	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == q_full) else $error("input stall does not follow queue");

endmodule
